// ===== sv/dtfr_pkg.sv =====
// Shared types and constants for the display text frame receiver.
// No dependencies; compiled first.
package dtfr_pkg;

    typedef enum logic [1:0] {
        CMD_RX   = 2'd0,
        CMD_READ = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_EMIT
    } t_state;

    localparam logic [1:0] LINE_ONE    = 2'd1;
    localparam logic [1:0] LINE_TWO    = 2'd2;
    localparam logic [1:0] ALIGN_NONE  = 2'd0;
    localparam logic [1:0] ALIGN_RIGHT = 2'd1;
    localparam logic [1:0] ALIGN_LEFT  = 2'd2;
    localparam logic [7:0] PAD_CHAR    = 8'h90;
    localparam logic [7:0] NUL_CHAR    = 8'h00;
    localparam logic [5:0] MAX_CHARS_RST = 6'd32;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic pad_en;
        logic emit;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic start_pad;
        logic pad_last;
    } t_dp_stat;

endpackage

// ===== sv/dtfr_ifs.sv =====
// Valid/ready channel interfaces: request input, result output, config write.
// Standalone; no package dependency.
interface dtfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic       line_select;
    logic [4:0] read_index;
    modport source(output valid, command, rx_byte, line_select, read_index, input ready);
    modport sink(input valid, command, rx_byte, line_select, read_index, output ready);
endinterface

interface dtfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_char;
    logic       line_one_ready;
    logic       line_two_ready;
    logic [1:0] target_line;
    logic [4:0] cursor_column;
    logic [1:0] alignment;
    logic [5:0] stored_length;
    logic       frame_done;
    logic       awaiting_header;
    modport source(output valid, read_char, line_one_ready, line_two_ready, target_line,
                   cursor_column, alignment, stored_length, frame_done, awaiting_header,
                   input ready);
    modport sink(input valid, read_char, line_one_ready, line_two_ready, target_line,
                 cursor_column, alignment, stored_length, frame_done, awaiting_header,
                 output ready);
endinterface

interface dtfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] max_chars;
    modport source(output valid, max_chars, input ready);
    modport sink(input valid, max_chars, output ready);
endinterface

// ===== sv/dtfr_ctrl.sv =====
// Sequencing FSM: accept, pad walk, result hand-off.
// Depends on dtfr_pkg.
module dtfr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    input  dtfr_pkg::t_dp_stat   i_stat,
    output dtfr_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_in_ready,
    output logic                 o_out_valid
);
    import dtfr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.start_pad ? S_PAD : S_EMIT;
                end
            end
            S_PAD: begin
                if (i_stat.pad_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.pad_en = (r_state == S_PAD);
        o_cmd.emit   = (r_state == S_EMIT) && out_free;
        n_out_valid  = o_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        o_out_valid  = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/dtfr_dp.sv =====
// Datapath: header/status registers, line buffer memory, pad pointer, result register.
// Depends on dtfr_pkg.
module dtfr_dp #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dtfr_pkg::t_ctrl_cmd  i_cmd,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_line_select,
    input  logic [4:0]           i_read_index,
    input  logic                 i_cfg_valid,
    input  logic [5:0]           i_cfg_max_chars,
    output dtfr_pkg::t_dp_stat   o_stat,
    output logic [7:0]           o_read_char,
    output logic                 o_line_one_ready,
    output logic                 o_line_two_ready,
    output logic [1:0]           o_target_line,
    output logic [4:0]           o_cursor_column,
    output logic [1:0]           o_alignment,
    output logic [5:0]           o_stored_length,
    output logic                 o_frame_done,
    output logic                 o_awaiting_header
);
    import dtfr_pkg::*;

    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int WPW = $clog2(BUF_DEPTH + 1);
    localparam int LW  = (WPW > 6) ? WPW : 6;
    localparam int IW  = (AW > 5) ? AW : 5;
    localparam int MD  = 2 << AW;

    logic [7:0]     r_header;
    logic [WPW-1:0] r_wp;
    logic [1:0]     r_line_mode;
    logic [4:0]     r_cursor;
    logic [1:0]     r_align;
    logic [5:0]     r_length;
    logic [1:0]     r_ready;
    logic [5:0]     r_max_chars;
    logic [AW-1:0]  r_pad_ptr;
    logic           r_pad_line;
    logic           r_done;
    logic [7:0]     r_mem_q;
    logic           r_rd_ok;
    logic [MD-1:0]  r_valid;
    logic [7:0]     mem [MD];

    t_cmd           cmd;
    logic           hdr_mode, is_line2, can_store, term, is_payload;
    logic [LW-1:0]  limit, mc_ext, wp_ext;
    logic [WPW-1:0] wp_inc, wp_new;
    logic [IW-1:0]  idx_w;
    logic [AW-1:0]  rd_addr;
    logic           in_range;
    logic           wr_en;
    logic [AW:0]    wr_addr;
    logic [7:0]     wr_data;

    always_comb begin
        cmd        = t_cmd'(i_command);
        hdr_mode   = (r_header == NUL_CHAR);
        is_line2   = (r_line_mode == LINE_TWO);
        mc_ext     = LW'(r_max_chars);
        wp_ext     = LW'(r_wp);
        limit      = (mc_ext < LW'(BUF_DEPTH)) ? mc_ext : LW'(BUF_DEPTH);
        can_store  = (wp_ext < limit);
        wp_inc     = r_wp + WPW'(1);
        wp_new     = can_store ? wp_inc : r_wp;
        term       = (i_rx_byte == NUL_CHAR);
        is_payload = i_cmd.accept && (cmd == CMD_RX) && !hdr_mode;
        idx_w      = IW'(i_read_index);
        rd_addr    = idx_w[AW-1:0];
        in_range   = (32'(i_read_index) < 32'(BUF_DEPTH));

        o_stat.start_pad = is_payload && term && (wp_new != '0);
        o_stat.pad_last  = (r_pad_ptr == AW'(BUF_DEPTH - 1));

        // one write port: pad fill while padding, else payload store on accept
        wr_en   = 1'b0;
        wr_addr = {r_pad_line, r_pad_ptr};
        wr_data = PAD_CHAR;
        if (i_cmd.pad_en) begin
            wr_en = 1'b1;
        end else if (is_payload && can_store) begin
            wr_en   = 1'b1;
            wr_addr = {is_line2, r_wp[AW-1:0]};
            wr_data = i_rx_byte;
        end
    end

    // line buffer memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.accept) begin
            r_mem_q <= mem[{i_line_select, rd_addr}];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= MAX_CHARS_RST;
        end else if (i_cfg_valid) begin
            r_max_chars <= i_cfg_max_chars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= NUL_CHAR;
            r_wp        <= '0;
            r_line_mode <= LINE_ONE;
            r_cursor    <= '0;
            r_align     <= ALIGN_NONE;
            r_length    <= '0;
            r_ready     <= '0;
        end else if (i_cmd.accept) begin
            unique case (cmd)
                CMD_RX: begin
                    if (hdr_mode) begin
                        r_header    <= i_rx_byte;
                        r_line_mode <= i_rx_byte[5] ? LINE_TWO : LINE_ONE;
                        if (i_rx_byte[5]) begin
                            r_cursor <= i_rx_byte[4:0];
                        end
                        unique case (i_rx_byte[7:6])
                            ALIGN_RIGHT: r_align <= ALIGN_RIGHT;
                            ALIGN_LEFT:  r_align <= ALIGN_LEFT;
                            default:     r_align <= ALIGN_NONE;
                        endcase
                    end else begin
                        if (can_store) begin
                            r_length <= 6'(wp_inc);
                        end
                        if (term) begin
                            r_ready  <= r_ready | (is_line2 ? 2'b10 : 2'b01);
                            r_header <= NUL_CHAR;
                            r_wp     <= '0;
                        end else begin
                            r_wp <= wp_new;
                        end
                    end
                end
                CMD_ACK: begin
                    r_ready <= r_ready & (i_line_select ? 2'b01 : 2'b10);
                end
                CMD_READ, CMD_NONE: ;
                default: ;
            endcase
        end
    end

    // pad pointer and per-request result bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pad_ptr  <= AW'(wp_new - WPW'(1));
            r_pad_line <= is_line2;
            r_done     <= is_payload && term;
            r_rd_ok    <= (cmd == CMD_READ) && in_range && r_valid[{i_line_select, rd_addr}];
        end else if (i_cmd.pad_en) begin
            r_pad_ptr <= r_pad_ptr + AW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_read_char       <= r_rd_ok ? r_mem_q : NUL_CHAR;
            o_line_one_ready  <= r_ready[0];
            o_line_two_ready  <= r_ready[1];
            o_target_line     <= r_line_mode;
            o_cursor_column   <= r_cursor;
            o_alignment       <= r_align;
            o_stored_length   <= r_length;
            o_frame_done      <= r_done;
            o_awaiting_header <= (r_header == NUL_CHAR);
        end
    end

endmodule

// ===== sv/display_text_frame_receiver_top.sv =====
// Display text frame receiver: top level joining controller and datapath.
// Depends on dtfr_pkg, dtfr_ifs, dtfr_ctrl and dtfr_dp.
//
// Takes one request at a time on i_in: a received serial byte (header or
// payload of a text frame for one of two display lines), a read of one
// buffer entry, or an acknowledge of a line's ready flag. Every request gives
// exactly one result on o_res holding the read character and the status after
// the request. A header, payload, read or acknowledge request moves from its
// accept to the S_EMIT state and, once the output register is free, into the
// result register; the next request can be taken after that. A terminating
// zero byte that leaves a stored count n > 0 first walks the pad pointer over
// the line buffer, one entry per cycle, writing the pad character from entry
// n-1 to the end, and only then reaches S_EMIT. The pad fill owns the single
// write port of the line buffer memory, so no request is taken meanwhile.
// i_in is ready again as soon as a result has moved into the output register,
// even if the sink stalls it; the next request then holds its result back
// until the sink takes the waiting one.
// The user must make i_cfg writes of max_chars only while the block is idle;
// the block itself does not enforce this. i_cfg is always ready.
// After reset both buffers read as zero; no clearing pass is needed.
module display_text_frame_receiver_top #(
    parameter int BUF_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dtfr_in_if.sink        i_in,
    dtfr_out_if.source     o_res,
    dtfr_cfg_if.sink       i_cfg
);
    import dtfr_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;
    logic      in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // sequencing: accept, pad fill, result hand-off
    dtfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (dp_stat),
        .o_cmd       (ctrl_cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (o_res.valid)
    );

    // registers, line buffers and result register
    dtfr_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctrl_cmd),
        .i_command         (i_in.command),
        .i_rx_byte         (i_in.rx_byte),
        .i_line_select     (i_in.line_select),
        .i_read_index      (i_in.read_index),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_max_chars   (i_cfg.max_chars),
        .o_stat            (dp_stat),
        .o_read_char       (o_res.read_char),
        .o_line_one_ready  (o_res.line_one_ready),
        .o_line_two_ready  (o_res.line_two_ready),
        .o_target_line     (o_res.target_line),
        .o_cursor_column   (o_res.cursor_column),
        .o_alignment       (o_res.alignment),
        .o_stored_length   (o_res.stored_length),
        .o_frame_done      (o_res.frame_done),
        .o_awaiting_header (o_res.awaiting_header)
    );

    // no new request while the pad fill owns the write port
    a_no_accept_in_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.pad_en |-> !in_ready)
        else $error("request accepted during pad fill");

    // a terminator with stored bytes always starts the pad fill
    a_pad_follows_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_cmd.accept && dp_stat.start_pad) |=> ctrl_cmd.pad_en)
        else $error("pad fill did not start after terminator");

    // result register never overwritten while the sink stalls
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.emit |-> !(o_res.valid && !o_res.ready))
        else $error("result overwritten while stalled");

    // a finished frame rearms header detection
    a_done_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done) |-> o_res.awaiting_header)
        else $error("frame done without header rearm");

endmodule
